[sv/mna_stamp_engine_defines.svh]
// ----------------------------------------------------------------------------
// MNA stamp engine assertion macros
// Concurrent assertion wrappers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MNA_STAMP_ENGINE_DEFINES_SVH
`define MNA_STAMP_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a consequent holds in the cycle after an antecedent.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSE_ASSERT(lbl, prop, msg)
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/mse_pkg.sv]
// ----------------------------------------------------------------------------
// MNA stamp engine package
// Command and status codes, fixed-point constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  // Default size of the unknown vector (rows of the system)
  localparam int DEF_MAX_UNKNOWNS = 64;

  // Width for index arithmetic: covers node + branch sums and the largest size
  localparam int CALC_W = 11;

  // Command codes
  localparam logic [3:0] CMD_CLEAR     = 4'd0;
  localparam logic [3:0] CMD_RESISTOR  = 4'd1;
  localparam logic [3:0] CMD_CURRENT   = 4'd2;
  localparam logic [3:0] CMD_VOLTAGE   = 4'd3;
  localparam logic [3:0] CMD_CAPACITOR = 4'd4;
  localparam logic [3:0] CMD_INDUCTOR  = 4'd5;
  localparam logic [3:0] CMD_ADMIT     = 4'd6;
  localparam logic [3:0] CMD_READ_MAT  = 4'd7;
  localparam logic [3:0] CMD_READ_RHS  = 4'd8;

  // Status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_RANGE  = 2'd1;
  localparam logic [1:0] STS_BRANCH = 2'd2;

  localparam logic [6:0] BRANCH_CAP = 7'd127;

  // Q32.32 constants
  localparam logic [63:0] Q_ONE      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q_INDUCTOR = 64'h000F_4240_0000_0000;
  localparam logic [63:0] Q_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN      = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic sub;
    logic ovr;
  } alu_ctl_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [6:0]  branch_count;
  } res_t;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_SLOT   = 6'b001000,
    ST_WR     = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

[sv/mse_ram.sv]
// ----------------------------------------------------------------------------
// MSE generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/mse_sat_alu.sv]
// ----------------------------------------------------------------------------
// MSE saturating adder
// Shared Q32.32 add / subtract with clamping, or pass-through for overwrite.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_sat_alu import mse_pkg::*; (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  alu_ctl_t    ctl_i,
  output logic [63:0] y_o
);

  logic [63:0] b_eff;
  logic [63:0] sum;
  logic        ovf;

  assign b_eff = ctl_i.sub ? ~b_i : b_i;
  assign sum   = a_i + b_eff + {63'd0, ctl_i.sub};
  // same operand signs but a result of the other sign
  assign ovf   = (a_i[63] == b_eff[63]) && (sum[63] != a_i[63]);

  always_comb begin
    if (ctl_i.ovr) begin
      y_o = b_i;
    end else if (ovf) begin
      y_o = a_i[63] ? Q_MIN : Q_MAX;
    end else begin
      y_o = sum;
    end
  end

endmodule

`default_nettype wire

[sv/mse_ctrl.sv]
// ----------------------------------------------------------------------------
// MSE stamp sequencer
// Walks the stamp slots of one item through the matrix and rhs memories
// and the shared saturating adder; runs the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mna_stamp_engine_defines.svh"

module mse_ctrl import mse_pkg::*; #(
  parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  logic [3:0]  command_i,
  input  logic [5:0]  node_a_i,
  input  logic [5:0]  node_b_i,
  input  logic [63:0] value_i,
  input  logic [5:0]  read_row_i,
  input  logic [5:0]  read_col_i,
  input  logic [5:0]  num_nodes_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  localparam int IDX_W     = $clog2(MAX_UNKNOWNS);
  localparam int MAT_DEPTH = MAX_UNKNOWNS * MAX_UNKNOWNS;
  localparam int MADDR_W   = $clog2(MAT_DEPTH);
  localparam logic [CALC_W-1:0]  MAX_C   = CALC_W'(MAX_UNKNOWNS);
  localparam logic [MADDR_W-1:0] MAX_A   = MADDR_W'(MAX_UNKNOWNS);
  localparam logic [MADDR_W-1:0] CLR_END = MADDR_W'(MAT_DEPTH - 1);

  localparam logic [2:0] SLOT_DIAG_A = 3'd0;
  localparam logic [2:0] SLOT_DIAG_B = 3'd1;
  localparam logic [2:0] SLOT_OFF_AB = 3'd2;
  localparam logic [2:0] SLOT_OFF_BA = 3'd3;
  localparam logic [2:0] SLOT_RHS_A  = 3'd4;
  localparam logic [2:0] SLOT_RHS_B  = 3'd5;

  state_e              state_q, state_d;
  logic [2:0]          slot_q, slot_d;
  logic [MADDR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic                clr_cmd_q, clr_cmd_d;
  logic [6:0]          branches_q, branches_d;
  logic [63:0]         value_q, value_d;
  logic [1:0]          status_q, status_d;

  logic [3:0]  cmd_q;
  logic [5:0]  na_q, nb_q, rr_q, rc_q;
  logic [63:0] val_q;
  logic        item_ld;

  logic [CALC_W-1:0] a_row, b_row, k_row;
  logic              na_ok, nb_ok, range_err, branch_err, read_err;

  logic              op_en, op_rhs;
  logic [CALC_W-1:0] op_row, op_col;
  logic [63:0]       operand;
  alu_ctl_t          alu_ctl;

  logic [MADDR_W-1:0] slot_addr, rd_addr;
  logic               mat_we, rhs_we;
  logic [MADDR_W-1:0] mat_waddr, mat_raddr;
  logic [IDX_W-1:0]   rhs_waddr, rhs_raddr;
  logic [63:0]        mat_wdata, rhs_wdata, mat_rdata, rhs_rdata, alu_a, alu_y;

  // ---- range checks ----
  assign a_row = CALC_W'(na_q) - CALC_W'(1);
  assign b_row = CALC_W'(nb_q) - CALC_W'(1);
  assign k_row = CALC_W'(num_nodes_i) + CALC_W'(branches_q);

  assign na_ok = (na_q == 6'd0) || ((na_q <= num_nodes_i) && (CALC_W'(na_q) <= MAX_C));
  assign nb_ok = (nb_q == 6'd0) || ((nb_q <= num_nodes_i) && (CALC_W'(nb_q) <= MAX_C));
  assign range_err  = !(na_ok && nb_ok);
  assign branch_err = (k_row >= MAX_C) || (branches_q >= BRANCH_CAP);
  assign read_err   = (CALC_W'(rr_q) >= MAX_C)
                   || ((cmd_q == CMD_READ_MAT) && (CALC_W'(rc_q) >= MAX_C));

  // ---- slot decode: at most one memory update per slot ----
  always_comb begin
    op_en       = 1'b0;
    op_rhs      = 1'b0;
    op_row      = a_row;
    op_col      = a_row;
    operand     = (cmd_q == CMD_INDUCTOR) ? Q_INDUCTOR : val_q;
    alu_ctl.sub = 1'b0;
    alu_ctl.ovr = 1'b0;
    case (cmd_q)
      CMD_RESISTOR, CMD_INDUCTOR: begin
        case (slot_q)
          SLOT_DIAG_A: begin
            op_en = (na_q != 6'd0);
          end
          SLOT_DIAG_B: begin
            op_en  = (nb_q != 6'd0);
            op_row = b_row;
            op_col = b_row;
          end
          SLOT_OFF_AB: begin
            op_en       = (na_q != 6'd0) && (nb_q != 6'd0);
            op_col      = b_row;
            alu_ctl.sub = 1'b1;
          end
          SLOT_OFF_BA: begin
            op_en       = (na_q != 6'd0) && (nb_q != 6'd0);
            op_row      = b_row;
            alu_ctl.sub = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_CURRENT: begin
        case (slot_q)
          SLOT_RHS_A: begin
            op_en  = (na_q != 6'd0);
            op_rhs = 1'b1;
          end
          SLOT_RHS_B: begin
            op_en       = (nb_q != 6'd0);
            op_rhs      = 1'b1;
            op_row      = b_row;
            alu_ctl.sub = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_VOLTAGE: begin
        operand = Q_ONE;
        case (slot_q)
          SLOT_DIAG_A: begin
            op_en  = (na_q != 6'd0);
            op_col = k_row;
          end
          SLOT_DIAG_B: begin
            op_en  = (na_q != 6'd0);
            op_row = k_row;
          end
          SLOT_OFF_AB: begin
            op_en       = (nb_q != 6'd0);
            op_row      = b_row;
            op_col      = k_row;
            alu_ctl.sub = 1'b1;
          end
          SLOT_OFF_BA: begin
            op_en       = (nb_q != 6'd0);
            op_row      = k_row;
            op_col      = b_row;
            alu_ctl.sub = 1'b1;
          end
          SLOT_RHS_A: begin
            // branch row takes the source voltage outright
            op_en       = 1'b1;
            op_rhs      = 1'b1;
            op_row      = k_row;
            operand     = val_q;
            alu_ctl.ovr = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_ADMIT: begin
        if (slot_q == SLOT_OFF_AB) begin
          op_en  = (na_q != 6'd0) && (nb_q != 6'd0);
          op_col = b_row;
        end
      end
      default: ;
    endcase
  end

  assign slot_addr = MADDR_W'(op_row[IDX_W-1:0]) * MAX_A + MADDR_W'(op_col[IDX_W-1:0]);
  assign rd_addr   = MADDR_W'(rr_q) * MAX_A + MADDR_W'(rc_q);

  // ---- memory ports ----
  // only a used stamp slot writes back; a read passes through ST_WR untouched
  assign mat_we    = (state_q == ST_CLEAR) || ((state_q == ST_WR) && op_en && !op_rhs);
  assign mat_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : slot_addr;
  assign mat_wdata = (state_q == ST_CLEAR) ? '0 : alu_y;
  assign mat_raddr = (state_q == ST_DECODE) ? rd_addr : slot_addr;

  assign rhs_we    = ((state_q == ST_CLEAR) && (clr_cnt_q < MAX_A))
                  || ((state_q == ST_WR) && op_en && op_rhs);
  assign rhs_waddr = (state_q == ST_CLEAR) ? clr_cnt_q[IDX_W-1:0] : op_row[IDX_W-1:0];
  assign rhs_wdata = (state_q == ST_CLEAR) ? '0 : alu_y;
  assign rhs_raddr = (state_q == ST_DECODE) ? IDX_W'(rr_q) : op_row[IDX_W-1:0];

  assign alu_a = op_rhs ? rhs_rdata : mat_rdata;

  mse_ram #(
    .WIDTH (64),
    .DEPTH (MAT_DEPTH)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_waddr),
    .wdata_i (mat_wdata),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  mse_ram #(
    .WIDTH (64),
    .DEPTH (MAX_UNKNOWNS)
  ) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (rhs_waddr),
    .wdata_i (rhs_wdata),
    .raddr_i (rhs_raddr),
    .rdata_o (rhs_rdata)
  );

  mse_sat_alu u_alu (
    .a_i   (alu_a),
    .b_i   (operand),
    .ctl_i (alu_ctl),
    .y_o   (alu_y)
  );

  // ---- sequencer ----
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    clr_cnt_d  = clr_cnt_q;
    clr_cmd_d  = clr_cmd_q;
    branches_d = branches_q;
    value_d    = value_q;
    status_d   = status_q;
    item_ld    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + MADDR_W'(1);
        if (clr_cnt_q == CLR_END) begin
          clr_cnt_d = '0;
          state_d   = clr_cmd_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          item_ld  = 1'b1;
          value_d  = '0;
          status_d = STS_OK;
          if (command_i == CMD_CLEAR) begin
            clr_cmd_d  = 1'b1;
            branches_d = '0;
            state_d    = ST_CLEAR;
          end else begin
            state_d = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        slot_d  = SLOT_DIAG_A;
        state_d = ST_DONE;
        case (cmd_q)
          CMD_RESISTOR, CMD_CURRENT, CMD_VOLTAGE, CMD_INDUCTOR, CMD_ADMIT: begin
            if (range_err) begin
              status_d = STS_RANGE;
            end else if ((cmd_q == CMD_VOLTAGE) && branch_err) begin
              status_d = STS_BRANCH;
            end else begin
              state_d = ST_SLOT;
            end
          end
          CMD_CAPACITOR: begin
            if (range_err) begin
              status_d = STS_RANGE;
            end
          end
          CMD_READ_MAT, CMD_READ_RHS: begin
            // read issued this cycle; data lands in ST_WR
            if (read_err) begin
              status_d = STS_RANGE;
            end else begin
              state_d = ST_WR;
            end
          end
          default: ;
        endcase
      end
      ST_SLOT: begin
        if (op_en) begin
          state_d = ST_WR;
        end else if (slot_q == SLOT_RHS_B) begin
          state_d = ST_DONE;
          if (cmd_q == CMD_VOLTAGE) begin
            branches_d = branches_q + 7'd1;
          end
        end else begin
          slot_d = slot_q + 3'd1;
        end
      end
      ST_WR: begin
        if ((cmd_q == CMD_READ_MAT) || (cmd_q == CMD_READ_RHS)) begin
          value_d = (cmd_q == CMD_READ_MAT) ? mat_rdata : rhs_rdata;
          state_d = ST_DONE;
        end else if (slot_q == SLOT_RHS_B) begin
          state_d = ST_DONE;
          if (cmd_q == CMD_VOLTAGE) begin
            branches_d = branches_q + 7'd1;
          end
        end else begin
          slot_d  = slot_q + 3'd1;
          state_d = ST_SLOT;
        end
      end
      ST_DONE: begin
        clr_cmd_d = 1'b0;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      slot_q     <= SLOT_DIAG_A;
      clr_cnt_q  <= '0;
      clr_cmd_q  <= 1'b0;
      branches_q <= '0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_cmd_q  <= clr_cmd_d;
      branches_q <= branches_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    if (item_ld) begin
      cmd_q <= command_i;
      na_q  <= node_a_i;
      nb_q  <= node_b_i;
      val_q <= value_i;
      rr_q  <= read_row_i;
      rc_q  <= read_col_i;
    end
  end

  assign item_ready_o       = (state_q == ST_IDLE);
  assign res_valid_o        = (state_q == ST_DONE);
  assign res_o.value        = value_q;
  assign res_o.status       = status_q;
  assign res_o.branch_count = branches_q;

  // ---- assertions ----
  `MSE_ASSERT(a_idle_no_write, (state_q == ST_IDLE) |-> (!mat_we && !rhs_we), "write while idle")
  `MSE_ASSERT(a_wr_after_read, (state_q == ST_WR) |-> ($past(state_q) == ST_SLOT || $past(state_q) == ST_DECODE), "write step without read")
  `MSE_ASSERT(a_branch_step, (branches_q != $past(branches_q)) |-> (branches_q == $past(branches_q) + 7'd1 || branches_q == 7'd0), "branch count jumped")
  `MSE_ASSERT(a_err_zero, (res_valid_o && status_q != STS_OK) |-> (value_q == 64'd0), "error result carries data")
  `MSE_ASSERT_NEXT(a_done_release, res_valid_o && res_ready_i, state_q == ST_IDLE, "result handed over but not idle")

endmodule

`default_nettype wire

[sv/mna_stamp_engine.sv]
// ----------------------------------------------------------------------------
// MNA stamp engine
// DC modified-nodal-analysis matrix and rhs builder, one device or command
// per transfer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the matrix memory to zero, one entry a cycle,
// and takes no item until done; num_nodes is sampled while an item is
// worked, so write it only while no item is in flight. A clear command runs
// the same sweep before its result. Every other item is worked one at a
// time; an accepted device other than a capacitor steps through six stamp
// slots sharing the matrix memory, the rhs memory and one saturating 64-bit
// adder: an unused slot is passed over, a used one is read, then written
// back through the saturating adder. A read goes from decode to the write
// step, which takes its data, and then to its result; a rejected device, a
// capacitor or an unused code goes from decode straight to its result. A
// finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mna_stamp_engine import mse_pkg::*; #(
  parameter int MAX_UNKNOWNS = DEF_MAX_UNKNOWNS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic [5:0]         node_a_i,
  input  logic [5:0]         node_b_i,
  input  logic signed [63:0] value_i,
  input  logic [5:0]         read_row_i,
  input  logic [5:0]         read_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] read_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         branch_count_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_data_i
);

  logic [5:0] num_nodes_q;
  logic       item_ready;
  logic       res_valid, res_ready;
  res_t       res;
  logic       out_valid_q;
  res_t       out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= '0;
    end else if (cfg_valid_i) begin
      num_nodes_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !item_ready;

  mse_ctrl #(
    .MAX_UNKNOWNS (MAX_UNKNOWNS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_ready_o (item_ready),
    .command_i    (command_i),
    .node_a_i     (node_a_i),
    .node_b_i     (node_b_i),
    .value_i      (value_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .num_nodes_i  (num_nodes_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register: refill when empty or when the held result transfers
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_res_q.value;
  assign status_o       = out_res_q.status;
  assign branch_count_o = out_res_q.branch_count;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// MNA stamp engine testbench
// Sends device records and commands through the input channel. A shadow
// copy of the conductance matrix, rhs vector and branch counter works out
// each expected result. Results are compared field by field in order while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import mse_pkg::*;

typedef struct packed {
  logic [3:0]  cmd;
  logic [5:0]  na;
  logic [5:0]  nb;
  logic [63:0] val;
  logic [5:0]  row;
  logic [5:0]  col;
} stamp_item_t;

localparam int UNKNOWNS = DEF_MAX_UNKNOWNS;

// Shadow of the system under construction, with the queue of results owed.
class mna_shadow;
  logic [63:0] g_mat [UNKNOWNS][UNKNOWNS];
  logic [63:0] rhs [UNKNOWNS];
  int          branches;
  int          nodes;
  res_t        due_q [$];
  int          mismatches;

  function new();
    nodes = 0;
    mismatches = 0;
    clear_stores();
  endfunction

  function void clear_stores();
    foreach (g_mat[r, c]) g_mat[r][c] = '0;
    foreach (rhs[r]) rhs[r] = '0;
    branches = 0;
  endfunction

  // Add or subtract; clamp towards the sign of x on overflow.
  function logic [63:0] sat_acc(logic [63:0] x, logic [63:0] y, bit neg);
    logic [63:0] s;
    logic        ovf;
    s = neg ? x - y : x + y;
    ovf = ((x[63] ^ y[63]) == neg) && (x[63] ^ s[63]);
    if (ovf) return x[63] ? Q_MIN : Q_MAX;
    return s;
  endfunction

  function void mat_acc(int r, int c, logic [63:0] v, bit neg);
    g_mat[r][c] = sat_acc(g_mat[r][c], v, neg);
  endfunction

  function bit node_ok(int n);
    return n == 0 || (n <= nodes && n - 1 < UNKNOWNS);
  endfunction

  function void stamp_g(int na, int nb, logic [63:0] g);
    if (na != 0) mat_acc(na - 1, na - 1, g, 1'b0);
    if (nb != 0) mat_acc(nb - 1, nb - 1, g, 1'b0);
    if (na != 0 && nb != 0) begin
      mat_acc(na - 1, nb - 1, g, 1'b1);
      mat_acc(nb - 1, na - 1, g, 1'b1);
    end
  endfunction

  function logic [1:0] stamp_device(stamp_item_t it);
    int na;
    int nb;
    int k;
    na = it.na;
    nb = it.nb;
    // node range is checked before branch availability
    if (!node_ok(na) || !node_ok(nb)) return STS_RANGE;
    case (it.cmd)
      CMD_RESISTOR: stamp_g(na, nb, it.val);
      CMD_INDUCTOR: stamp_g(na, nb, Q_INDUCTOR);
      CMD_CURRENT: begin
        if (na != 0) rhs[na - 1] = sat_acc(rhs[na - 1], it.val, 1'b0);
        if (nb != 0) rhs[nb - 1] = sat_acc(rhs[nb - 1], it.val, 1'b1);
      end
      CMD_VOLTAGE: begin
        k = nodes + branches;
        if (k >= UNKNOWNS || branches >= int'(BRANCH_CAP)) return STS_BRANCH;
        if (na != 0) begin
          mat_acc(na - 1, k, Q_ONE, 1'b0);
          mat_acc(k, na - 1, Q_ONE, 1'b0);
        end
        if (nb != 0) begin
          mat_acc(nb - 1, k, Q_ONE, 1'b1);
          mat_acc(k, nb - 1, Q_ONE, 1'b1);
        end
        rhs[k] = it.val;
        branches++;
      end
      CMD_ADMIT: begin
        if (na != 0 && nb != 0) mat_acc(na - 1, nb - 1, it.val, 1'b0);
      end
      default: ;  // capacitor: nothing to stamp
    endcase
    return STS_OK;
  endfunction

  function void take_item(stamp_item_t it);
    res_t want;
    want = '0;
    case (it.cmd)
      CMD_CLEAR: clear_stores();
      CMD_RESISTOR, CMD_CURRENT, CMD_VOLTAGE, CMD_CAPACITOR, CMD_INDUCTOR, CMD_ADMIT:
        want.status = stamp_device(it);
      CMD_READ_MAT: begin
        if (it.row < UNKNOWNS && it.col < UNKNOWNS) want.value = g_mat[it.row][it.col];
        else want.status = STS_RANGE;
      end
      CMD_READ_RHS: begin
        if (it.row < UNKNOWNS) want.value = rhs[it.row];
        else want.status = STS_RANGE;
      end
      default: ;
    endcase
    want.branch_count = 7'(branches);
    due_q.insert(due_q.size(), want);
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function void check_result(logic [63:0] v, logic [1:0] st, logic [6:0] bc);
    res_t got;
    res_t want;
    got.value = v;
    got.status = st;
    got.branch_count = bc;
    if (due_q.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: value=%h status=%0d branches=%0d", v, st, bc);
      mismatches++;
      return;
    end
    want = due_q.pop_front();
    if (got !== want) begin
      if (mismatches < 10)
        $display({"mismatch: want value=%h status=%0d branches=%0d,",
                  " got value=%h status=%0d branches=%0d"},
                 want.value, want.status, want.branch_count, v, st, bc);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  localparam int ITEMS       = 1900;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_IDLE    = 12;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  command_i   = '0;
  logic [5:0]  node_a_i    = '0;
  logic [5:0]  node_b_i    = '0;
  logic [63:0] value_i     = '0;
  logic [5:0]  read_row_i  = '0;
  logic [5:0]  read_col_i  = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [5:0]  cfg_data_i  = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [63:0] read_value_o;
  logic [1:0]         status_o;
  logic [6:0]         branch_count_o;
  logic               cfg_ready_o;

  mna_shadow mirror;
  bit        tx_idle;
  bit        rx_idle;
  int        hold_cnt = 0;
  int        sent = 0;

  always #5 clk_i = ~clk_i;

  mna_stamp_engine u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .value_i        (value_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .branch_count_o (branch_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Result side: check each transfer, then hold stall for a drawn number of cycles.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_result(read_value_o, status_o, branch_count_o);
      hold_cnt = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (hold_cnt != 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  task automatic send_item(stamp_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i  <= it.cmd;
    node_a_i   <= it.na;
    node_b_i   <= it.nb;
    value_i    <= it.val;
    read_row_i <= it.row;
    read_col_i <= it.col;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.take_item(it);
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_nodes(logic [5:0] n);
    wait_drained();
    cfg_data_i  <= n;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mirror.nodes = n;
  endtask

  function automatic stamp_item_t mk(logic [3:0] cmd, int na, int nb, logic [63:0] val,
                                     int row = 0, int col = 0);
    stamp_item_t it;
    it.cmd = cmd;
    it.na  = 6'(na);
    it.nb  = 6'(nb);
    it.val = val;
    it.row = 6'(row);
    it.col = 6'(col);
    return it;
  endfunction

  // Mostly in-range nodes, some ground, now and then any node at all.
  function automatic int draw_node();
    int p;
    p = $urandom_range(0, 19);
    if (p == 3) return $urandom_range(0, 63);
    if (p < 3 || mirror.nodes == 0) return 0;
    return $urandom_range(1, mirror.nodes);
  endfunction

  function automatic stamp_item_t draw_item();
    stamp_item_t it;
    int          p;
    int          used;
    it.na  = 6'(draw_node());
    it.nb  = 6'(draw_node());
    it.row = 6'($urandom_range(0, 63));
    it.col = 6'($urandom_range(0, 63));
    it.val = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: it.val = Q_MAX;
      1: it.val = Q_MIN;
      2: it.val = Q_ONE;
      3: it.val = -Q_ONE;
      4: it.val = '0;
      5, 6: ;
      default: it.val = {{28{it.val[35]}}, it.val[35:0]};
    endcase
    p = $urandom_range(0, 99);
    if (p < 18)      it.cmd = CMD_RESISTOR;
    else if (p < 30) it.cmd = CMD_CURRENT;
    else if (p < 40) it.cmd = CMD_VOLTAGE;
    else if (p < 44) it.cmd = CMD_CAPACITOR;
    else if (p < 50) it.cmd = CMD_INDUCTOR;
    else if (p < 62) it.cmd = CMD_ADMIT;
    else if (p < 82) it.cmd = CMD_READ_MAT;
    else if (p < 94) it.cmd = CMD_READ_RHS;
    else if (p < 99) it.cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else             it.cmd = CMD_CLEAR;
    // aim reads mostly at the rows in use
    used = mirror.nodes + mirror.branches;
    if ((it.cmd == CMD_READ_MAT || it.cmd == CMD_READ_RHS) && used > 0
        && $urandom_range(0, 4) != 0) begin
      it.row = 6'($urandom_range(0, used - 1));
      it.col = 6'($urandom_range(0, used - 1));
    end
    return it;
  endfunction

  initial begin
    int ph;
    int len;
    mirror = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_nodes(6'd3);
    send_item(mk(CMD_RESISTOR, 1, 2, Q_ONE));
    send_item(mk(CMD_RESISTOR, 3, 0, Q_MAX));
    send_item(mk(CMD_RESISTOR, 0, 3, Q_MAX));      // diagonal saturates high
    send_item(mk(CMD_ADMIT, 1, 3, Q_MIN));
    send_item(mk(CMD_ADMIT, 1, 3, -Q_ONE));        // saturates low
    send_item(mk(CMD_ADMIT, 0, 2, Q_ONE));
    send_item(mk(CMD_CURRENT, 1, 2, 64'h0123_4567_89AB_CDEF));
    send_item(mk(CMD_CURRENT, 0, 0, Q_MAX));
    send_item(mk(CMD_VOLTAGE, 1, 2, -Q_ONE));
    send_item(mk(CMD_VOLTAGE, 0, 0, 64'd7));       // grounded source still takes a row
    send_item(mk(CMD_CAPACITOR, 2, 3, Q_ONE));
    send_item(mk(CMD_INDUCTOR, 2, 3, '0));
    send_item(mk(CMD_RESISTOR, 4, 1, Q_ONE));      // node beyond num_nodes
    send_item(mk(CMD_VOLTAGE, 63, 0, Q_ONE));
    send_item(mk(CMD_READ_MAT, 0, 0, '0, 2, 2));
    send_item(mk(CMD_READ_MAT, 0, 0, '0, 0, 2));
    send_item(mk(CMD_READ_MAT, 63, 63, {64{1'b1}}, 3, 0));
    send_item(mk(CMD_READ_RHS, 0, 0, '0, 3));
    send_item(mk(CMD_READ_RHS, 0, 0, '0, 1));
    send_item(mk(CMD_UNUSED_LO, 1, 1, Q_ONE, 1, 1));
    send_item(mk(CMD_UNUSED_HI, 63, 63, {64{1'b1}}, 63, 63));
    send_item(mk(CMD_CLEAR, 0, 0, '0));
    send_item(mk(CMD_READ_MAT, 0, 0, '0, 2, 2));
    in_valid_i <= 1'b0;
    set_nodes(6'd63);
    send_item(mk(CMD_VOLTAGE, 63, 62, Q_MIN));     // takes the last row
    send_item(mk(CMD_VOLTAGE, 1, 0, Q_ONE));       // no rows left
    send_item(mk(CMD_READ_RHS, 0, 0, '0, 63));

    ph = 0;
    while (sent < ITEMS) begin
      in_valid_i <= 1'b0;
      case (ph % 5)
        0:       set_nodes(6'd0);
        1:       set_nodes(6'd63);
        default: set_nodes(6'($urandom_range(0, 63)));
      endcase
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) == 0) begin
        send_item(mk(CMD_CLEAR, 0, 0, '0));
        sent++;
      end
      len = $urandom_range(40, 120);
      repeat (len) begin
        send_item(draw_item());
        sent++;
      end
      ph++;
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (32) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/mse_pkg.sv
sv/mse_ram.sv
sv/mse_sat_alu.sv
sv/mse_ctrl.sv
sv/mna_stamp_engine.sv
bench/tb_top.sv
